### rtl/sbc_pkg.sv
// ----------------------------------------------------------------------------
// sbc_pkg
// Types, codes, limits and shared arithmetic for the balancing controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package sbc_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam int DIV_NUM_W  = 36;
  localparam int DIV_DEN_W  = 32;

  typedef struct packed {
    logic signed [16:0] pitch_angle;
    logic signed [15:0] pitch_rate;
    logic signed [15:0] yaw_rate;
    logic signed [15:0] left_count;
    logic signed [15:0] right_count;
    logic        [31:0] now_ms;
    logic        [2:0]  command;
  } sbc_in_t;

  typedef struct packed {
    logic signed [31:0] left_drive;
    logic signed [31:0] right_drive;
    logic        [1:0]  posture;
    logic               fault;
  } sbc_out_t;

  localparam logic [CFG_IDX_W-1:0] CFG_MID_ANGLE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BALANCE_KP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BALANCE_KD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_KP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_KI   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_KP    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_KD    = 3'd6;

  localparam logic [2:0] CMD_STOP  = 3'd0;
  localparam logic [2:0] CMD_FWD   = 3'd1;
  localparam logic [2:0] CMD_BACK  = 3'd2;
  localparam logic [2:0] CMD_LEFT  = 3'd3;
  localparam logic [2:0] CMD_RIGHT = 3'd4;

  localparam logic [1:0] POST_STAND = 2'd0;
  localparam logic [1:0] POST_HANG  = 2'd1;
  localparam logic [1:0] POST_FALL  = 2'd2;

  localparam logic signed [16:0] FALL_PITCH  = 17'sd15360;
  localparam logic signed [16:0] STAND_PITCH = 17'sd1280;
  localparam logic signed [31:0] HANG_SPEED  = 32'sd7000;
  localparam logic signed [15:0] HANG_RATE   = 16'sd1000;

  localparam logic signed [55:0] SPEED_INT_LIM = 56'sd2560000;
  localparam logic signed [33:0] SPEED_CMD_OFS = 34'sd12800;
  localparam logic signed [17:0] TURN_GOAL_LIM = 18'sd18400;
  localparam logic signed [55:0] TURN_INT_LIM  = 56'sd1800;
  localparam logic [6:0]         STEP_MIN      = 7'd24;
  localparam logic [6:0]         STEP_MAX      = 7'd80;
  localparam logic [DIV_NUM_W-1:0] STEP_NUM    = 36'd16000;
  localparam logic [31:0]        FILT_RECIP    = 32'hCCCCCCCD;

  typedef enum logic [4:0] {
    ST_IDLE, ST_BAL_M1, ST_BAL_M2, ST_BAL_ACC, ST_BAL_ST, ST_S_WAIT,
    ST_F_DIV, ST_F_WAIT, ST_I, ST_V_M1, ST_V_M2, ST_V_ACC, ST_V_ST,
    ST_STEP, ST_STEP_WAIT, ST_TI, ST_T_M1, ST_T_M2, ST_T_ACC, ST_T_ST,
    ST_DRV
  } sbc_state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LATCH, OP_BAL_M1, OP_BAL_M2, OP_BAL_ACC, OP_BAL_ST,
    OP_S_WAIT, OP_F_DIV, OP_F_WAIT, OP_I, OP_V_M1, OP_V_M2, OP_V_ACC,
    OP_V_ST, OP_STEP, OP_STEP_WAIT, OP_TI, OP_T_M1, OP_T_M2, OP_T_ACC,
    OP_T_ST, OP_DRV
  } sbc_op_t;

  typedef struct packed {
    sbc_op_t op;
  } sbc_cmd_t;

  typedef struct packed {
    logic primed;
    logic div_done;
    logic need_div;
    logic fallen;
    logic out_busy;
  } sbc_stat_t;

  typedef struct packed {
    logic [1:0] body;
    logic [1:0] prev;
    logic       fail;
  } sbc_post_t;

  function automatic logic signed [55:0] sbc_shr(input logic signed [55:0] v,
                                                 input int unsigned sh);
    logic [55:0] mag;
    logic [55:0] m;
    mag = v[55] ? 56'(-v) : 56'(v);
    m   = mag >> sh;
    return v[55] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [31:0] sbc_sat32(input logic signed [55:0] v);
    logic signed [31:0] r;
    if (v > 56'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -56'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = $signed(v[31:0]);
    end
    return r;
  endfunction

  function automatic sbc_post_t sbc_posture(input logic signed [31:0] speed,
                                            input logic signed [16:0] pitch,
                                            input logic signed [15:0] prate,
                                            input logic [1:0] body,
                                            input logic [1:0] prev);
    sbc_post_t r;
    r.body = body;
    r.prev = prev;
    r.fail = 1'b0;
    if (pitch < -FALL_PITCH || pitch > FALL_PITCH) begin
      r.body = POST_FALL;
    end else if (speed > HANG_SPEED && prate > -HANG_RATE && prate < HANG_RATE) begin
      r.body = POST_HANG;
    end
    if (r.prev == POST_STAND && r.body != POST_STAND) begin
      r.prev = r.body;
    end
    if (r.prev == POST_FALL) begin
      if (pitch >= -STAND_PITCH && pitch <= STAND_PITCH) begin
        r.prev = POST_STAND;
        r.body = POST_STAND;
      end else begin
        r.fail = 1'b1;
      end
    end else if (r.prev == POST_HANG) begin
      r.prev = POST_STAND;
    end
    return r;
  endfunction

endpackage

### rtl/sbc_div.sv
// ----------------------------------------------------------------------------
// sbc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module sbc_div
  import sbc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  output logic                 done,
  output logic [DIV_NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(DIV_NUM_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(DIV_NUM_W - 1);

  logic [DIV_DEN_W-1:0] rem_r;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_NUM_W-1:0] quo_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [DIV_DEN_W:0]   rem_sh;
  logic [DIV_DEN_W+1:0] diff;

  assign rem_sh = {rem_r, quo_r[DIV_NUM_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, den_r};
  assign done   = done_r;
  assign quo    = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      den_r <= den;
      quo_r <= num;
    end else if (busy_r) begin
      rem_r <= diff[DIV_DEN_W+1] ? rem_sh[DIV_DEN_W-1:0] : diff[DIV_DEN_W-1:0];
      quo_r <= {quo_r[DIV_NUM_W-2:0], ~diff[DIV_DEN_W+1]};
    end
  end

endmodule

### rtl/sbc_dp.sv
// ----------------------------------------------------------------------------
// sbc_dp
// Datapath: loop state, gains, shared multiplier, accumulator and divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module sbc_dp
  import sbc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  sbc_cmd_t              cmd,
  output sbc_stat_t             stat,
  input  sbc_in_t               in_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic                  out_valid,
  input  logic                  out_stall,
  output sbc_out_t              out_data
);

  sbc_in_t            in_r;
  logic signed [12:0] mid_r;
  logic [19:0]        bkp_r, bkd_r, skp_r, ski_r, tkp_r, tkd_r;
  logic [31:0]        last_time_r;
  logic               primed_r;
  logic signed [31:0] sf_r;
  logic signed [22:0] si_r;
  logic signed [15:0] goal_r;
  logic signed [11:0] ti_r;
  logic               tticks_r;
  logic [16:0]        tss_r;
  logic [1:0]         body_r, prev_r;
  logic               out_valid_r;
  sbc_out_t           out_r;

  logic signed [53:0] p_r;
  logic signed [55:0] acc_r;
  logic signed [31:0] b_r, v_r, t_r, f_r;
  logic signed [19:0] s_r;
  logic signed [22:0] i_r;
  logic               neg_r;
  logic [31:0]        fmag_r;

  logic signed [16:0] lc17, rc17, lc_half, rc_half, l_val, r_val;
  logic signed [17:0] sum_lr;
  logic [16:0]        abs_lr;
  logic signed [21:0] sum10;
  logic [31:0]        dt_raw, dt;
  logic signed [35:0] fsum;
  logic [63:0]        fprod;
  logic [28:0]        fquo;
  logic signed [33:0] i_adj, i_sum;
  logic signed [22:0] i_clamp;
  logic               turning, use_yaw;
  logic [6:0]         q_clamp, step_sel;
  logic signed [17:0] goal_sum;
  logic signed [15:0] goal_nxt;
  logic signed [23:0] tx;
  logic signed [55:0] tsh;
  logic signed [11:0] ti_nxt;
  logic signed [32:0] ma;
  logic signed [20:0] mb;
  logic signed [33:0] dsum1, dsum2;
  logic signed [31:0] d1, d2;
  sbc_post_t          post1, post2;
  logic               div_start, div_done;
  logic [DIV_NUM_W-1:0] div_num, div_q;
  logic [DIV_DEN_W-1:0] div_den;
  logic signed [35:0] q_sgn;

  sbc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_q)
  );

  assign lc17    = 17'(in_r.left_count);
  assign rc17    = 17'(in_r.right_count);
  assign lc_half = lc17[16] ? -((-lc17) >>> 1) : (lc17 >>> 1);
  assign rc_half = rc17[16] ? -((-rc17) >>> 1) : (rc17 >>> 1);
  assign l_val   = -lc_half;
  assign r_val   = rc_half;
  assign sum_lr  = 18'(l_val) + 18'(r_val);
  assign abs_lr  = sum_lr[17] ? 17'(-sum_lr) : 17'(sum_lr);
  assign sum10   = 22'(sum_lr) * 22'sd10;
  assign dt_raw  = in_r.now_ms - last_time_r;
  assign dt      = (dt_raw == '0) ? 32'd1 : dt_raw;
  assign fsum    = 36'(sf_r) * 36'sd7 + 36'(s_r) * 36'sd768;
  assign fprod   = 64'(fmag_r) * 64'(FILT_RECIP);
  assign fquo    = fprod[63:35];
  assign q_sgn   = neg_r ? -$signed(div_q) : $signed(div_q);

  assign turning = in_r.command inside {CMD_LEFT, CMD_RIGHT};
  assign use_yaw = !(in_r.command inside {CMD_FWD, CMD_BACK});

  always_comb begin
    case (in_r.command)
      CMD_FWD:  i_adj = -SPEED_CMD_OFS;
      CMD_BACK: i_adj = SPEED_CMD_OFS;
      default:  i_adj = '0;
    endcase
    i_sum = 34'(si_r) + 34'(f_r) + i_adj;
    if (56'(i_sum) > SPEED_INT_LIM) begin
      i_clamp = 23'(SPEED_INT_LIM);
    end else if (56'(i_sum) < -SPEED_INT_LIM) begin
      i_clamp = 23'(-SPEED_INT_LIM);
    end else begin
      i_clamp = 23'(i_sum);
    end
  end

  always_comb begin
    if (div_q < DIV_NUM_W'(STEP_MIN)) begin
      q_clamp = STEP_MIN;
    end else if (div_q > DIV_NUM_W'(STEP_MAX)) begin
      q_clamp = STEP_MAX;
    end else begin
      q_clamp = div_q[6:0];
    end
    if (cmd.op == OP_STEP_WAIT) begin
      step_sel = q_clamp;
    end else begin
      step_sel = turning ? STEP_MAX : STEP_MIN;
    end
    case (in_r.command)
      CMD_LEFT:  goal_sum = 18'(goal_r) + $signed({11'd0, step_sel});
      CMD_RIGHT: goal_sum = 18'(goal_r) - $signed({11'd0, step_sel});
      default:   goal_sum = '0;
    endcase
    if (goal_sum > TURN_GOAL_LIM) begin
      goal_nxt = 16'(TURN_GOAL_LIM);
    end else if (goal_sum < -TURN_GOAL_LIM) begin
      goal_nxt = 16'(-TURN_GOAL_LIM);
    end else begin
      goal_nxt = 16'(goal_sum);
    end
  end

  always_comb begin
    tx  = (24'(ti_r) + 24'(l_val) - 24'(r_val)) * 24'sd8 - 24'(goal_r);
    tsh = sbc_shr(56'(tx), 3);
    if (tsh > TURN_INT_LIM) begin
      ti_nxt = 12'(TURN_INT_LIM);
    end else if (tsh < -TURN_INT_LIM) begin
      ti_nxt = 12'(-TURN_INT_LIM);
    end else begin
      ti_nxt = 12'(tsh);
    end
  end

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.op)
      OP_BAL_M1: begin
        ma = 33'(18'(in_r.pitch_angle) - 18'(mid_r));
        mb = $signed({1'b0, bkp_r});
      end
      OP_BAL_M2: begin
        ma = 33'(in_r.pitch_rate);
        mb = $signed({1'b0, bkd_r});
      end
      OP_V_M1: begin
        ma = 33'(f_r);
        mb = $signed({1'b0, skp_r});
      end
      OP_V_M2: begin
        ma = 33'(i_r);
        mb = $signed({1'b0, ski_r});
      end
      OP_T_M1: begin
        ma = 33'(ti_r);
        mb = $signed({1'b0, tkp_r});
      end
      OP_T_M2: begin
        ma = 33'(in_r.yaw_rate);
        mb = $signed({1'b0, tkd_r});
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (cmd.op)
      OP_BAL_ST: begin
        div_start = 1'b1;
        div_num   = DIV_NUM_W'(sum10[21] ? 22'(-sum10) : 22'(sum10));
        div_den   = dt;
      end
      OP_STEP: begin
        div_start = turning && (tss_r != '0);
        div_num   = STEP_NUM;
        div_den   = DIV_DEN_W'(tss_r);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  assign dsum1 = 34'(b_r) - 34'(v_r) - 34'(t_r);
  assign dsum2 = 34'(b_r) - 34'(v_r) + 34'(t_r);
  assign d1    = sbc_sat32(56'(dsum1));
  assign d2    = sbc_sat32(56'(dsum2));
  assign post1 = sbc_posture(32'sd0, in_r.pitch_angle, in_r.pitch_rate, body_r, prev_r);
  assign post2 = sbc_posture(d1, in_r.pitch_angle, in_r.pitch_rate, body_r, prev_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_r       <= -13'sd256;
      bkp_r       <= 20'd76800;
      bkd_r       <= 20'd256;
      skp_r       <= 20'd23040;
      ski_r       <= 20'd128;
      tkp_r       <= 20'd256;
      tkd_r       <= 20'd21;
      last_time_r <= '0;
      primed_r    <= 1'b0;
      sf_r        <= '0;
      si_r        <= '0;
      goal_r      <= '0;
      ti_r        <= '0;
      tticks_r    <= 1'b0;
      tss_r       <= '0;
      body_r      <= POST_FALL;
      prev_r      <= POST_STAND;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_MID_ANGLE:  mid_r <= $signed(cfg_wdata[12:0]);
          CFG_BALANCE_KP: bkp_r <= cfg_wdata;
          CFG_BALANCE_KD: bkd_r <= cfg_wdata;
          CFG_SPEED_KP:   skp_r <= cfg_wdata;
          CFG_SPEED_KI:   ski_r <= cfg_wdata;
          CFG_TURN_KP:    tkp_r <= cfg_wdata;
          CFG_TURN_KD:    tkd_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid_r && !out_stall && cmd.op != OP_DRV) begin
        out_valid_r <= 1'b0;
      end
      case (cmd.op)
        OP_LATCH: begin
          if (!primed_r) begin
            last_time_r <= in_data.now_ms;
            primed_r    <= 1'b1;
          end
        end
        OP_V_ST: begin
          body_r <= post1.body;
          prev_r <= post1.prev;
          if (post1.fail) begin
            sf_r <= '0;
            si_r <= '0;
          end else begin
            sf_r <= f_r;
            si_r <= i_r;
          end
          if (turning) begin
            if (!tticks_r) begin
              tss_r    <= abs_lr;
              tticks_r <= 1'b1;
            end
          end else begin
            tticks_r <= 1'b0;
            tss_r    <= '0;
          end
        end
        OP_STEP: begin
          if (!(turning && (tss_r != '0))) begin
            goal_r <= goal_nxt;
          end
        end
        OP_STEP_WAIT: begin
          if (div_done) begin
            goal_r <= goal_nxt;
          end
        end
        OP_TI: begin
          if (body_r != POST_FALL) begin
            ti_r <= ti_nxt;
          end
        end
        OP_DRV: begin
          last_time_r <= in_r.now_ms;
          body_r      <= post2.body;
          prev_r      <= post2.prev;
          out_valid_r <= 1'b1;
          if (post2.fail) begin
            primed_r <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    p_r <= 54'(ma) * 54'(mb);
    case (cmd.op)
      OP_LATCH:   in_r <= in_data;
      OP_BAL_M2:  acc_r <= 56'(p_r);
      OP_BAL_ACC: acc_r <= acc_r + (56'(p_r) <<< 8);
      OP_BAL_ST: begin
        b_r   <= 32'(sbc_shr(acc_r, 16));
        neg_r <= sum10[21];
      end
      OP_S_WAIT: begin
        if (div_done) begin
          s_r <= 20'(q_sgn);
        end
      end
      OP_F_DIV: begin
        neg_r  <= fsum[35];
        fmag_r <= fsum[35] ? 32'(-fsum) : 32'(fsum);
      end
      OP_F_WAIT: begin
        f_r <= neg_r ? -$signed({3'b000, fquo}) : $signed({3'b000, fquo});
      end
      OP_I:       i_r <= i_clamp;
      OP_V_M2:    acc_r <= 56'(p_r);
      OP_V_ACC:   acc_r <= acc_r + 56'(p_r);
      OP_V_ST:    v_r <= sbc_sat32(sbc_shr(acc_r, 16));
      OP_STEP:    neg_r <= 1'b0;
      OP_TI: begin
        if (body_r == POST_FALL) begin
          t_r <= '0;
        end
      end
      OP_T_M2:    acc_r <= 56'(p_r);
      OP_T_ACC:   acc_r <= acc_r + (use_yaw ? 56'(p_r) : 56'sd0);
      OP_T_ST:    t_r <= 32'(sbc_shr(acc_r, 8));
      OP_DRV: begin
        out_r.left_drive  <= post2.fail ? 32'sd0 : d1;
        out_r.right_drive <= post2.fail ? 32'sd0 : d2;
        out_r.posture     <= post2.body;
        out_r.fault       <= post2.fail;
      end
      default: ;
    endcase
  end

  assign out_valid     = out_valid_r;
  assign out_data      = out_r;
  assign stat.primed   = primed_r;
  assign stat.div_done = div_done;
  assign stat.need_div = turning && (tss_r != '0);
  assign stat.fallen   = (body_r == POST_FALL);
  assign stat.out_busy = out_valid_r && out_stall;

endmodule

### rtl/sbc_ctrl.sv
// ----------------------------------------------------------------------------
// sbc_ctrl
// Sequencer for one control tick: issues datapath operations in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module sbc_ctrl
  import sbc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  sbc_stat_t stat,
  output sbc_cmd_t  cmd
);

  sbc_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LATCH;
          state_nxt = stat.primed ? ST_BAL_M1 : ST_IDLE;
        end
      end
      ST_BAL_M1: begin
        cmd.op    = OP_BAL_M1;
        state_nxt = ST_BAL_M2;
      end
      ST_BAL_M2: begin
        cmd.op    = OP_BAL_M2;
        state_nxt = ST_BAL_ACC;
      end
      ST_BAL_ACC: begin
        cmd.op    = OP_BAL_ACC;
        state_nxt = ST_BAL_ST;
      end
      ST_BAL_ST: begin
        cmd.op    = OP_BAL_ST;
        state_nxt = ST_S_WAIT;
      end
      ST_S_WAIT: begin
        cmd.op = OP_S_WAIT;
        if (stat.div_done) begin
          state_nxt = ST_F_DIV;
        end
      end
      ST_F_DIV: begin
        cmd.op    = OP_F_DIV;
        state_nxt = ST_F_WAIT;
      end
      ST_F_WAIT: begin
        cmd.op    = OP_F_WAIT;
        state_nxt = ST_I;
      end
      ST_I: begin
        cmd.op    = OP_I;
        state_nxt = ST_V_M1;
      end
      ST_V_M1: begin
        cmd.op    = OP_V_M1;
        state_nxt = ST_V_M2;
      end
      ST_V_M2: begin
        cmd.op    = OP_V_M2;
        state_nxt = ST_V_ACC;
      end
      ST_V_ACC: begin
        cmd.op    = OP_V_ACC;
        state_nxt = ST_V_ST;
      end
      ST_V_ST: begin
        cmd.op    = OP_V_ST;
        state_nxt = ST_STEP;
      end
      ST_STEP: begin
        cmd.op    = OP_STEP;
        state_nxt = stat.need_div ? ST_STEP_WAIT : ST_TI;
      end
      ST_STEP_WAIT: begin
        cmd.op = OP_STEP_WAIT;
        if (stat.div_done) begin
          state_nxt = ST_TI;
        end
      end
      ST_TI: begin
        cmd.op    = OP_TI;
        state_nxt = stat.fallen ? ST_DRV : ST_T_M1;
      end
      ST_T_M1: begin
        cmd.op    = OP_T_M1;
        state_nxt = ST_T_M2;
      end
      ST_T_M2: begin
        cmd.op    = OP_T_M2;
        state_nxt = ST_T_ACC;
      end
      ST_T_ACC: begin
        cmd.op    = OP_T_ACC;
        state_nxt = ST_T_ST;
      end
      ST_T_ST: begin
        cmd.op    = OP_T_ST;
        state_nxt = ST_DRV;
      end
      ST_DRV: begin
        if (!stat.out_busy) begin
          cmd.op    = OP_DRV;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/self_balancing_cascade_controller_core.sv
// ----------------------------------------------------------------------------
// self_balancing_cascade_controller_core
// A tick runs its balance, speed, turn-step, turn and drive steps in order,
// plus any output stall. The shared divider runs for the speed sample and,
// when turning with a step count held, for the turn step; the turn products
// run only when not fallen. One tick at a time: the next is taken the cycle
// after this one's result is registered. A priming tick only latches its time.
// Reset (rst_n low, synchronous): gains to defaults, loop state cleared,
// posture fallen, no result pending.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module self_balancing_cascade_controller_core
  import sbc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  sbc_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output sbc_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  sbc_cmd_t  cmd;
  sbc_stat_t stat;

  sbc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  sbc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef SYNTH
  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.fault |-> out_data.left_drive == 32'sd0 &&
                                    out_data.right_drive == 32'sd0)
    else $error("fault transaction with nonzero drive");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.op == OP_DRV))
    else $error("result raised without drive step");

  a_accept_latch: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |-> cmd.op == OP_LATCH)
    else $error("input transaction taken without latch");
`endif

endmodule
